>>> rtl/fmd_pkg.sv
// ----------------------------------------------------------------------------
// fmd_pkg - shared types and constants of the frame deframer
// Event and error codes, header layout constants and the result record.
// ----------------------------------------------------------------------------
package fmd_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int POS_W        = 4;

    localparam logic [POS_W-1:0] POS_VERSION = POS_W'(4);
    localparam logic [POS_W-1:0] POS_FLAGS   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_ID      = POS_W'(8);
    localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(12);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(HEADER_BYTES - 1);

    localparam logic [7:0] MAGIC_BYTES [4] = '{8'h50, 8'h4D, 8'h54, 8'h33};

    localparam logic [7:0] CFG_IDX_VERSION = 8'd0;
    localparam logic [7:0] CFG_IDX_MAX_LEN = 8'd1;

    localparam logic [7:0]  VERSION_RESET = 8'd3;
    localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

    typedef enum logic [2:0] {
        EV_HEADER  = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_EMPTY   = 3'd2,
        EV_ERROR   = 3'd3,
        EV_IDLE    = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_MAGIC   = 3'd1,
        ERR_VERSION = 3'd2,
        ERR_FLAGS   = 3'd3,
        ERR_SIZE    = 3'd4
    } err_t;

    typedef struct packed {
        event_t      evt;
        logic [7:0]  data;
        logic [3:0]  flags;
        logic [15:0] ftype;
        logic [31:0] req_id;
        logic [31:0] length;
        logic        last;
        err_t        err;
    } res_t;

endpackage

>>> rtl/fmd_hdr_check.sv
// ----------------------------------------------------------------------------
// fmd_hdr_check - header validation
// Ranks magic, version, flags rules and payload limit into one error code.
// ----------------------------------------------------------------------------
module fmd_hdr_check
    import fmd_pkg::*;
(
    input  logic        magic_mismatch,
    input  logic [7:0]  version,
    input  logic [7:0]  flags,
    input  logic [31:0] length,
    input  logic [7:0]  expected_version,
    input  logic [31:0] max_payload_len,
    output err_t        err
);

    logic flags_bad;

    // upper bits set, error without response, more without stream
    assign flags_bad = (flags[7:4] != 4'd0)
                    || (flags[1] && !flags[0])
                    || (flags[3] && !flags[2]);

    always_comb
    begin
        if (magic_mismatch)
            err = ERR_MAGIC;
        else if (version != expected_version)
            err = ERR_VERSION;
        else if (flags_bad)
            err = ERR_FLAGS;
        else if (length > max_payload_len)
            err = ERR_SIZE;
        else
            err = ERR_NONE;
    end

endmodule

>>> rtl/framed_message_deframer_unit.sv
// ----------------------------------------------------------------------------
// framed_message_deframer_unit - length-prefixed frame deframer
// Splits a byte stream into 16-byte headers and payloads, one event per byte.
// ----------------------------------------------------------------------------
// Every accepted byte yields exactly one event, registered in the output buffer.
// The block takes one byte per clock: each byte needs only a header counter
// step, a field shift and, on the last header byte, one 32-bit compare
// against max_payload_len. Results leave through a two-entry output buffer
// (main register plus skid register), so a byte is still accepted in the
// cycle that a finished event waits on out_ready; in_ready drops only when
// both entries are full. Header bytes answer with a header event carrying
// zero fields; payload bytes come out tagged with flags, type, request id and
// length, the final one with last_of_frame set. A frame with zero length
// gives a single empty-frame event. The first failed header check reports an
// error code once; afterwards every byte is answered with an idle event until
// reset. Configuration writes are always taken (cfg_ready is tied high) and
// apply from the next header check onward; unknown indexes are dropped.
module framed_message_deframer_unit
    import fmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [7:0]  out_byte,
    output logic [3:0]  frame_flags,
    output logic [15:0] frame_type,
    output logic [31:0] frame_req_id,
    output logic [31:0] payload_len,
    output logic        last_of_frame,
    output logic [2:0]  error_code,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration
    logic [7:0]  expected_version_reg;
    logic [31:0] max_payload_len_reg;

    // deframer state
    logic [POS_W-1:0] header_count_reg, header_count_next;
    logic             in_payload_reg,   in_payload_next;
    logic             magic_mismatch_reg, magic_mismatch_next;
    logic [7:0]       version_reg,      version_next;
    logic [7:0]       flags_reg,        flags_next;
    logic [15:0]      type_reg,         type_next;
    logic [31:0]      id_reg,           id_next;
    logic [31:0]      length_reg,       length_next;
    logic [31:0]      bytes_left_reg,   bytes_left_next;
    logic             error_latched_reg, error_latched_next;

    // output buffer
    res_t main_reg;
    logic main_valid_reg;
    res_t skid_reg;
    logic skid_valid_reg;

    res_t        res_next;
    logic        in_fire;
    logic        out_fire;
    logic [31:0] length_full;
    logic [31:0] bytes_left_dec;
    logic        mismatch_now;
    err_t        hdr_err;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = main_valid_reg && out_ready;

    // length as it stands once the current byte is shifted in
    assign length_full    = {length_reg[23:0], in_byte};
    assign bytes_left_dec = bytes_left_reg - 32'd1;
    assign mismatch_now   = magic_mismatch_reg
                         || ((header_count_reg < POS_VERSION)
                             && (in_byte != MAGIC_BYTES[header_count_reg[1:0]]));

    fmd_hdr_check u_hdr_check (
        .magic_mismatch   (magic_mismatch_reg),
        .version          (version_reg),
        .flags            (flags_reg),
        .length           (length_full),
        .expected_version (expected_version_reg),
        .max_payload_len  (max_payload_len_reg),
        .err              (hdr_err)
    );

    // next state and the event for the byte on the input port
    always_comb
    begin
        header_count_next   = header_count_reg;
        in_payload_next     = in_payload_reg;
        magic_mismatch_next = magic_mismatch_reg;
        version_next        = version_reg;
        flags_next          = flags_reg;
        type_next           = type_reg;
        id_next             = id_reg;
        length_next         = length_reg;
        bytes_left_next     = bytes_left_reg;
        error_latched_next  = error_latched_reg;
        res_next            = '0;
        res_next.evt        = EV_HEADER;
        res_next.err        = ERR_NONE;

        if (error_latched_reg)
        begin
            res_next.evt = EV_IDLE;
        end
        else if (in_payload_reg)
        begin
            res_next.evt    = EV_PAYLOAD;
            res_next.data   = in_byte;
            res_next.flags  = flags_reg[3:0];
            res_next.ftype  = type_reg;
            res_next.req_id = id_reg;
            res_next.length = length_reg;
            bytes_left_next = bytes_left_dec;
            if (bytes_left_dec == 32'd0)
            begin
                res_next.last     = 1'b1;
                in_payload_next   = 1'b0;
                header_count_next = '0;
            end
        end
        else
        begin
            // collect the header field this byte belongs to
            magic_mismatch_next = mismatch_now;
            if (header_count_reg == POS_VERSION)
                version_next = in_byte;
            else if (header_count_reg == POS_FLAGS)
                flags_next = in_byte;
            else if (header_count_reg > POS_FLAGS && header_count_reg < POS_ID)
                type_next = {type_reg[7:0], in_byte};
            else if (header_count_reg >= POS_ID && header_count_reg < POS_LENGTH)
                id_next = {id_reg[23:0], in_byte};
            else if (header_count_reg >= POS_LENGTH)
                length_next = length_full;

            if (header_count_reg != POS_LAST)
            begin
                header_count_next = header_count_reg + POS_W'(1);
            end
            else if (hdr_err != ERR_NONE)
            begin
                error_latched_next = 1'b1;
                res_next.evt       = EV_ERROR;
                res_next.err       = hdr_err;
            end
            else
            begin
                magic_mismatch_next = 1'b0;
                header_count_next   = '0;
                if (length_full == 32'd0)
                begin
                    res_next.evt    = EV_EMPTY;
                    res_next.flags  = flags_reg[3:0];
                    res_next.ftype  = type_reg;
                    res_next.req_id = id_reg;
                    res_next.length = length_full;
                    res_next.last   = 1'b1;
                end
                else
                begin
                    in_payload_next = 1'b1;
                    bytes_left_next = length_full;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_version_reg <= VERSION_RESET;
            max_payload_len_reg  <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IDX_VERSION: expected_version_reg <= cfg_data[7:0];
                CFG_IDX_MAX_LEN: max_payload_len_reg  <= cfg_data;
                default:         ; // drop writes to unknown indexes
            endcase
        end
    end

    // deframer state, advanced on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg   <= '0;
            in_payload_reg     <= 1'b0;
            magic_mismatch_reg <= 1'b0;
            version_reg        <= '0;
            flags_reg          <= '0;
            type_reg           <= '0;
            id_reg             <= '0;
            length_reg         <= '0;
            bytes_left_reg     <= '0;
            error_latched_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            header_count_reg   <= header_count_next;
            in_payload_reg     <= in_payload_next;
            magic_mismatch_reg <= magic_mismatch_next;
            version_reg        <= version_next;
            flags_reg          <= flags_next;
            type_reg           <= type_next;
            id_reg             <= id_next;
            length_reg         <= length_next;
            bytes_left_reg     <= bytes_left_next;
            error_latched_reg  <= error_latched_next;
        end
    end

    // output buffer: main register feeds the port, skid catches a request
    // that arrives while the main entry is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !main_valid_reg)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (in_fire)
                main_reg <= res_next;
        end
        else if (in_fire)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid     = main_valid_reg;
    assign event_res     = main_reg.evt;
    assign out_byte      = main_reg.data;
    assign frame_flags   = main_reg.flags;
    assign frame_type    = main_reg.ftype;
    assign frame_req_id  = main_reg.req_id;
    assign payload_len   = main_reg.length;
    assign last_of_frame = main_reg.last;
    assign error_code    = main_reg.err;

`ifndef NO_ASSERTIONS
    // payload phase and error state never coexist
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_payload_reg && error_latched_reg))
        else $error("payload phase while error latched");

    // an open payload always has bytes still to come
    assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (bytes_left_reg != 32'd0))
        else $error("payload phase with zero bytes left");

    // error state holds until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        error_latched_reg |=> error_latched_reg)
        else $error("error state released without reset");

    // skid entry is only occupied behind a held main entry
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry filled with main entry empty");
`endif

endmodule

>>> test/framed_message_deframer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_message_deframer_unit_tb - self-checking bench for the frame deframer
// Streams framed byte sequences through the deframer under several register
// settings, predicts every event in a scoreboard and compares each field.
// The run ends with one broken header, which locks the block in error.
// ----------------------------------------------------------------------------
module framed_message_deframer_unit_tb
    import fmd_pkg::*;
();

    // "PMT3" as it appears on the wire, first byte in the top octet
    localparam logic [31:0] FRAME_MAGIC     = 32'h504D_5433;
    localparam int          IDLE_PERCENT    = 6;
    localparam int          STALL_LIMIT     = 2000;
    localparam int          RANDOM_ITEMS    = 1100;
    localparam int          PHASES          = 5;
    localparam int          SHORT_PAYLOAD   = 24;
    localparam int          MISMATCH_PRINTS = 100;

    typedef enum int {
        BREAK_MAGIC,
        BREAK_VERSION,
        BREAK_FLAGS,
        BREAK_SIZE
    } frame_break_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the deframer state for every accepted byte request
    // and holds the events it must produce, oldest first.
    // ------------------------------------------------------------------------
    class deframer_scoreboard;
        logic [7:0]  version_want;
        logic [31:0] length_limit;
        logic [3:0]  header_pos;
        bit          in_body;
        bit          magic_bad;
        bit          stuck;
        logic [7:0]  version_q;
        logic [7:0]  flags_q;
        logic [15:0] type_q;
        logic [31:0] id_q;
        logic [31:0] length_q;
        logic [31:0] body_left;
        res_t        expected_events[$];
        int          mismatches;
        int          events_checked;
        int          frames_closed;
        int          body_bytes;

        function new();
            version_want   = 8'd3;
            length_limit   = 32'd1048576;
            header_pos     = '0;
            in_body        = 1'b0;
            magic_bad      = 1'b0;
            stuck          = 1'b0;
            version_q      = '0;
            flags_q        = '0;
            type_q         = '0;
            id_q           = '0;
            length_q       = '0;
            body_left      = '0;
            mismatches     = 0;
            events_checked = 0;
            frames_closed  = 0;
            body_bytes     = 0;
        endfunction

        function void write_register(logic [7:0] index, logic [31:0] value);
            // unknown indexes leave both settings alone
            if (index == CFG_IDX_VERSION)
                version_want = value[7:0];
            else if (index == CFG_IDX_MAX_LEN)
                length_limit = value;
        endfunction

        static function bit flags_rejected(logic [7:0] f);
            return (f[7:4] != 4'd0) || (f[1] && !f[0]) || (f[3] && !f[2]);
        endfunction

        function res_t frame_event(event_t ev);
            res_t r;
            r        = '0;
            r.evt    = ev;
            r.err    = ERR_NONE;
            r.flags  = flags_q[3:0];
            r.ftype  = type_q;
            r.req_id = id_q;
            r.length = length_q;
            return r;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void note_request(logic [7:0] b);
            res_t       r;
            err_t       code;
            logic [7:0] magic_byte;
            r     = '0;
            r.evt = EV_HEADER;
            r.err = ERR_NONE;
            code  = ERR_NONE;
            if (stuck) begin
                r.evt = EV_IDLE;
            end
            else if (in_body) begin
                r      = frame_event(EV_PAYLOAD);
                r.data = b;
                body_left = body_left - 32'd1;
                body_bytes++;
                if (body_left == 32'd0) begin
                    r.last     = 1'b1;
                    in_body    = 1'b0;
                    header_pos = '0;
                    frames_closed++;
                end
            end
            else begin
                // collect the header field that this position belongs to
                if (header_pos < 4'd4) begin
                    magic_byte = 8'(FRAME_MAGIC >> (8 * (3 - int'(header_pos))));
                    if (b != magic_byte)
                        magic_bad = 1'b1;
                end
                else if (header_pos == 4'd4)
                    version_q = b;
                else if (header_pos == 4'd5)
                    flags_q = b;
                else if (header_pos < 4'd8)
                    type_q = {type_q[7:0], b};
                else if (header_pos < 4'd12)
                    id_q = {id_q[23:0], b};
                else
                    length_q = {length_q[23:0], b};

                if (header_pos != 4'(HEADER_BYTES - 1)) begin
                    header_pos = header_pos + 4'd1;
                end
                else begin
                    // header complete: checks run in priority order
                    if (magic_bad)
                        code = ERR_MAGIC;
                    else if (version_q != version_want)
                        code = ERR_VERSION;
                    else if (flags_rejected(flags_q))
                        code = ERR_FLAGS;
                    else if (length_q > length_limit)
                        code = ERR_SIZE;

                    if (code != ERR_NONE) begin
                        stuck = 1'b1;
                        r.evt = EV_ERROR;
                        r.err = code;
                    end
                    else begin
                        magic_bad  = 1'b0;
                        header_pos = '0;
                        if (length_q == 32'd0) begin
                            r      = frame_event(EV_EMPTY);
                            r.last = 1'b1;
                            frames_closed++;
                        end
                        else begin
                            in_body   = 1'b1;
                            body_left = length_q;
                        end
                    end
                end
            end
            expected_events.insert(expected_events.size(), r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= MISMATCH_PRINTS)
                $display("[%0t] event %0d: %s is %0h, expected %0h",
                         $time, events_checked, what, got, want);
        endtask

        task check_result(res_t got);
            res_t want;
            events_checked++;
            if (expected_events.size() == 0) begin
                report_mismatch("event with none pending", 32'(got.evt), 32'd0);
                return;
            end
            want = expected_events.pop_front();
            if (got.evt != want.evt)
                report_mismatch("event_res", 32'(got.evt), 32'(want.evt));
            if (got.data != want.data)
                report_mismatch("out_byte", 32'(got.data), 32'(want.data));
            if (got.flags != want.flags)
                report_mismatch("frame_flags", 32'(got.flags), 32'(want.flags));
            if (got.ftype != want.ftype)
                report_mismatch("frame_type", 32'(got.ftype), 32'(want.ftype));
            if (got.req_id != want.req_id)
                report_mismatch("frame_req_id", got.req_id, want.req_id);
            if (got.length != want.length)
                report_mismatch("payload_len", got.length, want.length);
            if (got.last != want.last)
                report_mismatch("last_of_frame", 32'(got.last), 32'(want.last));
            if (got.err != want.err)
                report_mismatch("error_code", 32'(got.err), 32'(want.err));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    logic        in_ready;
    logic        out_valid;
    logic [2:0]  event_res;
    logic [7:0]  out_byte;
    logic [3:0]  frame_flags;
    logic [15:0] frame_type;
    logic [31:0] frame_req_id;
    logic [31:0] payload_len;
    logic        last_of_frame;
    logic [2:0]  error_code;
    logic        cfg_ready;

    deframer_scoreboard sb;
    res_t               seen_event;
    bit                 steady_run   = 1'b0;  // suppress all idling on both sides
    int                 quiet_cycles = 0;
    int                 items_sent   = 0;
    int                 writes_done  = 0;
    int                 settings_run = 0;
    frame_break_t       failure_kind;

    framed_message_deframer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_res     (event_res),
        .out_byte      (out_byte),
        .frame_flags   (frame_flags),
        .frame_type    (frame_type),
        .frame_req_id  (frame_req_id),
        .payload_len   (payload_len),
        .last_of_frame (last_of_frame),
        .error_code    (error_code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Result side: check every accepted event, stall out_ready at random and
    // stop the run if no channel moves a request for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                seen_event.evt    = event_t'(event_res);
                seen_event.data   = out_byte;
                seen_event.flags  = frame_flags;
                seen_event.ftype  = frame_type;
                seen_event.req_id = frame_req_id;
                seen_event.length = payload_len;
                seen_event.last   = last_of_frame;
                seen_event.err    = err_t'(error_code);
                sb.check_result(seen_event);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
        out_ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one byte request and hold it until the block takes it. Valid may
    // first be held low at random.
    task automatic send_byte(input logic [7:0] b);
        if (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(b);
        items_sent++;
    endtask

    // Drop valid and hold until every pending event has come back. Always
    // wait on the clock first so valid is never lowered and raised at once.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Leave cfg_valid high across back-to-back writes; the caller drops it.
    task automatic write_register(input logic [7:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_register(index, value);
        writes_done++;
    endtask

    // Settings change only with the block drained. Optionally poke an index
    // that does not exist, which must change nothing.
    task automatic apply_settings(input logic [7:0] version, input logic [31:0] limit,
                                  input bit poke_unknown);
        wait_drained();
        write_register(CFG_IDX_VERSION, version);
        write_register(CFG_IDX_MAX_LEN, limit);
        if (poke_unknown)
            write_register(8'($urandom_range(int'(CFG_IDX_MAX_LEN) + 1, 255)), $urandom);
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_run++;
    endtask

    // Stream a header with the given fields, then body_count random bytes.
    task automatic send_frame(input logic [31:0] magic, input logic [7:0] version,
                              input logic [7:0] flags, input logic [15:0] ftype,
                              input logic [31:0] req, input logic [31:0] length,
                              input int body_count);
        logic [127:0] header;
        header = {magic, version, flags, ftype, req, length};
        for (int i = 0; i < HEADER_BYTES; i++)
            send_byte(header[127 - 8 * i -: 8]);
        for (int i = 0; i < body_count; i++)
            send_byte(8'($urandom));
    endtask

    // Any flags value that passes the rules: error needs response, more
    // needs stream, upper nibble clear.
    function automatic logic [7:0] legal_flags();
        logic [7:0] f;
        f = {4'd0, 4'($urandom)};
        if (f[1])
            f[0] = 1'b1;
        if (f[3])
            f[2] = 1'b1;
        return f;
    endfunction

    // Well-formed frame under the current settings. Keep payloads short, hit
    // empty frames and the payload cap (the length limit if lower) now and then.
    task automatic send_good_frame();
        logic [31:0] cap;
        logic [31:0] length;
        cap = (sb.length_limit < SHORT_PAYLOAD) ? sb.length_limit : 32'(SHORT_PAYLOAD);
        case ($urandom_range(9))
            0:       length = 32'd0;
            1:       length = cap;
            default: length = 32'($urandom_range(int'(cap)));
        endcase
        send_frame(FRAME_MAGIC, sb.version_want, legal_flags(), 16'($urandom), $urandom,
                   length, int'(length));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int          goal;
        bit          drained_once;
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  flags;
        logic [31:0] length;

        sb           = new();
        drained_once = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, an empty frame with flags, type and request id
        // at their largest legal values, then a short frame with those fields at zero.
        send_frame(FRAME_MAGIC, 8'd3, 8'h0F, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 0);
        send_frame(FRAME_MAGIC, 8'd3, 8'h00, 16'h0000, 32'h0000_0000, 32'd2, 2);

        // Random frames under several settings, extremes among them.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       apply_settings(8'd0, 32'd0, 1'b0);            // empty frames only
                1:       apply_settings(8'd255, 32'hFFFF_FFFF, 1'b1);
                2:       apply_settings(8'($urandom), 32'($urandom_range(40, 1)), 1'b0);
                3:       apply_settings(8'd3, 32'd1048576, 1'b1);
                default: apply_settings(8'($urandom), 32'($urandom_range(1000, 24)), 1'b0);
            endcase
            // one full phase runs with no idling on either side
            steady_run <= (p == 3);
            goal = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < goal) begin
                send_good_frame();
                // once, hold the sender mid-phase until every event is back
                if (p == 2 && !drained_once && items_sent > goal - 100) begin
                    wait_drained();
                    drained_once = 1'b1;
                end
            end
        end
        steady_run <= 1'b0;

        // Final frame breaks one header rule. Lower-priority fields are left
        // random so the priority of the checks is exercised as well.
        apply_settings(8'($urandom), 32'($urandom_range(500)), 1'b0);
        send_good_frame();
        failure_kind = frame_break_t'($urandom_range(3));
        magic   = FRAME_MAGIC;
        version = sb.version_want;
        flags   = legal_flags();
        length  = 32'($urandom_range(int'(sb.length_limit)));
        case (failure_kind)
            BREAK_MAGIC:
            begin
                magic   = FRAME_MAGIC ^ (32'($urandom_range(255, 1)) << (8 * $urandom_range(3)));
                version = 8'($urandom);
                flags   = 8'($urandom);
                length  = $urandom;
            end
            BREAK_VERSION:
            begin
                version = sb.version_want ^ 8'($urandom_range(255, 1));
                flags   = 8'($urandom);
                length  = $urandom;
            end
            BREAK_FLAGS:
            begin
                do
                    flags = 8'($urandom);
                while (!deframer_scoreboard::flags_rejected(flags));
                length = $urandom;
            end
            default:
            begin
                length = $urandom;
                if (length <= sb.length_limit)
                    length = sb.length_limit + 32'd1;
            end
        endcase
        send_frame(magic, version, flags, 16'($urandom), $urandom, length, 0);

        // The block is now locked: every further byte must be answered with an idle event.
        repeat (20) send_byte(8'($urandom));

        wait_drained();
        repeat (4) @(posedge clk);

        $display("Run covered %0d byte requests, %0d closed frames, %0d payload bytes, %0d writes over %0d settings.",
                 items_sent, sb.frames_closed, sb.body_bytes, writes_done, settings_run);
        $display("Ended on a %s header fault and ignored bytes afterward; %0d mismatches.",
                 failure_kind.name(), sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
